[hw/rtl/fcpa_pkg.sv]
// ----------------------------------------------------------------------------
// fcpa_pkg
// Shared types, codes and defaults for the fixed chunk pool allocator.
// ----------------------------------------------------------------------------
package fcpa_pkg;

	localparam int unsigned MAX_CHUNKS_DEF = 256;
	localparam int unsigned NODE_BYTES_DEF = 4;

	localparam int unsigned ADDR_W       = 32;
	localparam int unsigned CFG_W        = 32;
	localparam int unsigned CHUNK_REQ_W  = 16;
	localparam int unsigned CHUNK_W      = 17;
	localparam int unsigned ALIGN_W      = 4;
	localparam int unsigned FREE_COUNT_W = 9;
	localparam int unsigned REG_IDX_W    = 2;

	localparam logic [CHUNK_REQ_W-1:0] CHUNK_REQ_RST = 16'd8;
	localparam logic [ALIGN_W-1:0]     ALIGN_RST     = 4'd3;

	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_FREE    = 2'd1,
		CMD_REBUILD = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_EMPTY  = 3'd1,
		ST_BOUNDS = 3'd2,
		ST_NULL   = 3'd3,
		ST_FAULT  = 3'd4
	} status_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_BASE   = 2'd0,
		REG_LENGTH = 2'd1,
		REG_CHUNK  = 2'd2,
		REG_ALIGN  = 2'd3
	} reg_idx_t;

	// controller -> datapath commands
	typedef struct packed {
		logic accept_op;      // alloc / free / nop taken this cycle
		logic accept_rebuild; // rebuild taken this cycle
		logic prep;           // register aligned geometry
		logic check;          // validate geometry
		logic load;           // set up the walk
		logic walk;           // push one chunk
	} fcpa_ctl_t;

	// datapath -> controller status
	typedef struct packed {
		logic cfg_bad;
		logic walk_done;
	} fcpa_sts_t;

endpackage

[hw/rtl/fcpa_ctrl.sv]
// ----------------------------------------------------------------------------
// fcpa_ctrl
// Sequencer for the pool allocator: alloc, free and nop ops and the rebuild walk.
// ----------------------------------------------------------------------------
module fcpa_ctrl
	import fcpa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] cmd,
	input  fcpa_sts_t  sts,
	output fcpa_ctl_t  ctl,
	output logic       busy
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_CHECK,
		S_LOAD,
		S_WALK
	} state_t;

	state_t state_q;

	logic take;

	assign take = start && (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);

	always_comb begin
		ctl                = '0;
		ctl.accept_op      = take && (cmd_t'(cmd) != CMD_REBUILD);
		ctl.accept_rebuild = take && (cmd_t'(cmd) == CMD_REBUILD);
		ctl.prep           = (state_q == S_PREP);
		ctl.check          = (state_q == S_CHECK);
		ctl.load           = (state_q == S_LOAD);
		ctl.walk           = (state_q == S_WALK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (ctl.accept_rebuild) state_q <= S_PREP;
				end
				S_PREP: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					state_q <= sts.cfg_bad ? S_IDLE : S_LOAD;
				end
				S_LOAD: begin
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (sts.walk_done) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/fcpa_dp.sv]
// ----------------------------------------------------------------------------
// fcpa_dp
// Datapath: config registers, pool geometry, free stack memory, result regs.
// ----------------------------------------------------------------------------
module fcpa_dp
	import fcpa_pkg::*;
#(
	parameter int unsigned MAX_CHUNKS = MAX_CHUNKS_DEF,
	parameter int unsigned NODE_BYTES = NODE_BYTES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fcpa_ctl_t               ctl,
	output fcpa_sts_t               sts,
	input  logic [1:0]              cmd,
	input  logic [ADDR_W-1:0]       address,
	input  logic                    cfg_we,
	input  logic [REG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	output logic                    done,
	output logic [ADDR_W-1:0]       chunk_address,
	output logic [2:0]              status,
	output logic [FREE_COUNT_W-1:0] free_count
);

	localparam int unsigned AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int unsigned DW = $clog2(MAX_CHUNKS + 1);

	// config
	logic [ADDR_W-1:0]      base_q;
	logic [ADDR_W-1:0]      length_q;
	logic [CHUNK_REQ_W-1:0] chunk_req_q;
	logic [ALIGN_W-1:0]     align_q;

	// geometry
	logic [ADDR_W-1:0]  aligned_start_q;
	logic [ADDR_W-1:0]  usable_q;
	logic [CHUNK_W-1:0] chunk_q;

	// rebuild pipeline
	logic [ADDR_W:0]        start_s1;
	logic [CHUNK_REQ_W-1:0] pad_s1;
	logic [CHUNK_W-1:0]     chunk_s1;
	logic                   over_s1;

	// walk
	logic [ADDR_W:0]   rem_q;
	logic [ADDR_W-1:0] walk_addr_q;

	logic [DW-1:0] depth_q, depth_d;
	logic          done_q;
	status_t       status_q, status_d;

	logic [ADDR_W-1:0] mem [MAX_CHUNKS];
	logic [ADDR_W-1:0] rd_q;
	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [ADDR_W-1:0] mem_wdata;

	logic [CHUNK_REQ_W-1:0] mask;
	logic [ADDR_W:0]        start_c;
	logic [CHUNK_W-1:0]     chunk_c;
	logic [ADDR_W:0]        endsum_c;
	logic [ADDR_W:0]        usable_c;
	logic                   cfg_bad;
	logic [ADDR_W:0]        diff_c;
	logic                   more, last_slot, walk_done;
	logic [ADDR_W-1:0]      off_c;
	logic                   oob;
	logic [DW-1:0]          depth_dec;
	logic                   emit;

	// prep: align base and chunk up, padding from the low bits of -base
	assign mask     = ~({CHUNK_REQ_W{1'b1}} << align_q);
	assign start_c  = ({1'b0, base_q} + {17'd0, mask}) & ~{17'd0, mask};
	assign chunk_c  = ({1'b0, chunk_req_q} + {1'b0, mask}) & ~{1'b0, mask};
	assign endsum_c = {1'b0, base_q} + {1'b0, length_q};

	// check
	assign usable_c = {1'b0, length_q} - {17'd0, pad_s1};
	assign cfg_bad  = start_s1[ADDR_W] || over_s1 || usable_c[ADDR_W]
		|| (chunk_s1 < CHUNK_W'(NODE_BYTES))
		|| (usable_c[ADDR_W-1:0] < {15'd0, chunk_s1});

	// walk: rem_q holds bytes left after the chunk being pushed
	assign diff_c    = rem_q - {16'd0, chunk_q};
	assign more      = !diff_c[ADDR_W];
	assign last_slot = (depth_q == DW'(MAX_CHUNKS - 1));
	assign walk_done = last_slot || !more;

	assign sts.cfg_bad   = cfg_bad;
	assign sts.walk_done = walk_done;

	assign off_c     = address - aligned_start_q;
	assign oob       = (address < aligned_start_q) || (off_c >= usable_q);
	assign depth_dec = depth_q - DW'(1);

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = depth_q[AW-1:0];
		mem_raddr = depth_dec[AW-1:0];
		mem_wdata = address;
		depth_d   = depth_q;
		status_d  = ST_OK;
		emit      = 1'b0;
		if (ctl.accept_op) begin
			emit = 1'b1;
			case (cmd_t'(cmd))
				CMD_ALLOC: begin
					if (depth_q == '0) begin
						status_d = ST_EMPTY;
					end else begin
						mem_re  = 1'b1;
						depth_d = depth_dec;
					end
				end
				CMD_FREE: begin
					if (address == '0) begin
						status_d = ST_NULL;
					end else if (oob) begin
						status_d = ST_BOUNDS;
					end else if (depth_q == DW'(MAX_CHUNKS)) begin
						status_d = ST_FAULT;
					end else begin
						mem_we  = 1'b1;
						depth_d = depth_q + DW'(1);
					end
				end
				default: begin
					status_d = ST_OK;
				end
			endcase
		end else if (ctl.accept_rebuild) begin
			depth_d = '0;
		end else if (ctl.check) begin
			if (cfg_bad) begin
				emit     = 1'b1;
				status_d = ST_FAULT;
			end
		end else if (ctl.walk) begin
			mem_we    = 1'b1;
			mem_wdata = walk_addr_q;
			depth_d   = depth_q + DW'(1);
			if (walk_done) begin
				emit     = 1'b1;
				status_d = (last_slot && more) ? ST_FAULT : ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q          <= '0;
			length_q        <= '0;
			chunk_req_q     <= CHUNK_REQ_RST;
			align_q         <= ALIGN_RST;
			aligned_start_q <= '0;
			usable_q        <= '0;
			chunk_q         <= '0;
			depth_q         <= '0;
			done_q          <= 1'b0;
			status_q        <= ST_OK;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_BASE:   base_q      <= cfg_data;
					REG_LENGTH: length_q    <= cfg_data;
					REG_CHUNK:  chunk_req_q <= cfg_data[CHUNK_REQ_W-1:0];
					REG_ALIGN:  align_q     <= cfg_data[ALIGN_W-1:0];
					default:    base_q      <= base_q;
				endcase
			end
			if (ctl.check) begin
				if (cfg_bad) begin
					aligned_start_q <= '0;
					usable_q        <= '0;
					chunk_q         <= '0;
				end else begin
					aligned_start_q <= start_s1[ADDR_W-1:0];
					usable_q        <= usable_c[ADDR_W-1:0];
					chunk_q         <= chunk_s1;
				end
			end
			depth_q <= depth_d;
			done_q  <= emit;
			if (emit) status_q <= status_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.prep) begin
			start_s1 <= start_c;
			pad_s1   <= (~base_q[CHUNK_REQ_W-1:0] + CHUNK_REQ_W'(1)) & mask;
			chunk_s1 <= chunk_c;
			over_s1  <= (endsum_c > {1'b1, {ADDR_W{1'b0}}});
		end
		if (ctl.load) begin
			rem_q       <= {1'b0, usable_q} - {16'd0, chunk_q};
			walk_addr_q <= aligned_start_q;
		end else if (ctl.walk && !walk_done) begin
			rem_q       <= diff_c;
			walk_addr_q <= walk_addr_q + {15'd0, chunk_q};
		end
	end

	// free stack; the read register doubles as the chunk_address output
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end else if (emit) begin
			rd_q <= '0;
		end
	end

	assign done          = done_q;
	assign chunk_address = rd_q;
	assign status        = status_q;
	assign free_count    = FREE_COUNT_W'(depth_q);

endmodule

[hw/rtl/fixed_chunk_pool_allocator.sv]
// ----------------------------------------------------------------------------
// fixed_chunk_pool_allocator
// Fixed-size chunk pool with a LIFO free stack of chunk addresses.
//
//   channel  handshake        payload
//   -------  ---------------  -------------------------------------
//   command  start & !busy    cmd, address
//   result   done (1 cycle)   chunk_address, status, free_count
//   config   cfg_we           cfg_index, cfg_data
//
// Alloc, free and nop: result strobed the next cycle, busy stays low so a new
// command may follow right away (one stack memory port).
// Rebuild: the prep, check and load states, then the walk state pushing one
// chunk at a time, at most MAX_CHUNKS, or prep and check alone when the
// geometry is rejected; busy is high for that span and done marks the end.
// Reset empties the pool; no clearing pass is needed.
// The result receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
module fixed_chunk_pool_allocator
	import fcpa_pkg::*;
#(
	parameter int unsigned MAX_CHUNKS = MAX_CHUNKS_DEF,
	parameter int unsigned NODE_BYTES = NODE_BYTES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              cmd,
	input  logic [ADDR_W-1:0]       address,
	output logic                    done,
	output logic [ADDR_W-1:0]       chunk_address,
	output logic [2:0]              status,
	output logic [FREE_COUNT_W-1:0] free_count,
	input  logic                    cfg_we,
	input  logic [REG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);

	fcpa_ctl_t ctl;
	fcpa_sts_t sts;

	fcpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	fcpa_dp #(
		.MAX_CHUNKS (MAX_CHUNKS),
		.NODE_BYTES (NODE_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.cmd           (cmd),
		.address       (address),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.done          (done),
		.chunk_address (chunk_address),
		.status        (status),
		.free_count    (free_count)
	);

endmodule

[hw/rtl/fcpa_checker.sv]
// ----------------------------------------------------------------------------
// fcpa_checker
// Port-level checks on command and result timing of the pool allocator.
// ----------------------------------------------------------------------------
module fcpa_checker
	import fcpa_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic [1:0]              cmd,
	input logic                    done,
	input logic [ADDR_W-1:0]       chunk_address,
	input logic [2:0]              status,
	input logic [FREE_COUNT_W-1:0] free_count
);

	// an alloc, free or nop command answers on the very next cycle
	a_op_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd != CMD_REBUILD) |=> done)
		else $error("missing result after single-cycle command");

	// a rebuild transaction keeps the block busy
	a_rebuild_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd == CMD_REBUILD) |=> busy && !done)
		else $error("rebuild did not hold busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while busy");

	a_fail_null: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != ST_OK) |-> (chunk_address == '0))
		else $error("failed transaction returned an address");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_EMPTY) |-> (free_count == '0))
		else $error("empty status with nonzero free count");

endmodule

bind fixed_chunk_pool_allocator fcpa_checker u_fcpa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.cmd           (cmd),
	.done          (done),
	.chunk_address (chunk_address),
	.status        (status),
	.free_count    (free_count)
);

[tb/sv/fixed_chunk_pool_allocator_test.sv]
// ----------------------------------------------------------------------------
// fixed_chunk_pool_allocator_test
// Self-checking bench for the chunk pool allocator. A predictor in the bench
// tracks the free stack and pool geometry, and each strobed result is checked
// against it. Directed cases cover the empty pool, bounds, null and full-stack
// releases, rebuild overflow and every bad-geometry rule. Random traffic then
// runs alloc/free sequences over many pool geometries with varied start gaps.
// ----------------------------------------------------------------------------
module fixed_chunk_pool_allocator_test;
	import fcpa_pkg::*;

	localparam int unsigned POOL_SLOTS  = MAX_CHUNKS_DEF;
	localparam int unsigned QUIET_LIMIT = 2000;

	typedef struct {
		logic [ADDR_W-1:0]       addr;
		status_t                 st;
		logic [FREE_COUNT_W-1:0] count;
	} pool_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [1:0]              cmd;
	logic [ADDR_W-1:0]       address;
	logic                    done;
	logic [ADDR_W-1:0]       chunk_address;
	logic [2:0]              status;
	logic [FREE_COUNT_W-1:0] free_count;
	logic                    cfg_we;
	logic [REG_IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]        cfg_data;

	fixed_chunk_pool_allocator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.address       (address),
		.done          (done),
		.chunk_address (chunk_address),
		.status        (status),
		.free_count    (free_count),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	logic [31:0] reg_base;
	logic [31:0] reg_len;
	logic [15:0] reg_chunk;
	logic [3:0]  reg_align;
	logic [31:0] pool_stack [POOL_SLOTS];
	int unsigned pool_depth;
	logic [31:0] pool_start;
	logic [31:0] pool_usable;

	pool_result_t pending_results[$];

	int err_count;
	int results_checked;
	int rebuilds;
	int geometries;
	int status_seen [5];
	int idle_pct;
	int quiet_cycles;

	function automatic status_t rebuild_pool();
		longint unsigned mask, base, first, pad, chunk, count, i;
		mask  = (64'd1 << reg_align) - 64'd1;
		base  = {32'd0, reg_base};
		first = (base + mask) & ~mask;
		pad   = first - base;
		chunk = ({48'd0, reg_chunk} + mask) & ~mask;
		pool_depth  = 0;
		pool_start  = '0;
		pool_usable = '0;
		if (first > 64'hFFFF_FFFF || base + {32'd0, reg_len} > 64'h1_0000_0000 ||
				pad > {32'd0, reg_len} || chunk < NODE_BYTES_DEF ||
				{32'd0, reg_len} - pad < chunk) begin
			return ST_FAULT;
		end
		pool_start  = first[31:0];
		pool_usable = reg_len - pad[31:0];
		count = {32'd0, pool_usable} / chunk;
		for (i = 0; i < count && i < POOL_SLOTS; i++) begin
			pool_stack[i] = 32'(first + i * chunk);
			pool_depth    = int'(i) + 1;
		end
		return (count > POOL_SLOTS) ? ST_FAULT : ST_OK;
	endfunction

	function automatic pool_result_t predict_step(cmd_t c, logic [31:0] a);
		pool_result_t r;
		r.addr = '0;
		r.st   = ST_OK;
		case (c)
			CMD_ALLOC: begin
				if (pool_depth == 0) begin
					r.st = ST_EMPTY;
				end else begin
					pool_depth--;
					r.addr = pool_stack[pool_depth];
				end
			end
			CMD_FREE: begin
				if (a == '0) begin
					r.st = ST_NULL;
				end else if (a < pool_start || a - pool_start >= pool_usable) begin
					r.st = ST_BOUNDS;
				end else if (pool_depth >= POOL_SLOTS) begin
					r.st = ST_FAULT;
				end else begin
					pool_stack[pool_depth] = a;
					pool_depth++;
				end
			end
			CMD_REBUILD: r.st = rebuild_pool();
			default: ;
		endcase
		r.count = pool_depth[FREE_COUNT_W-1:0];
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		pool_result_t exp;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result strobed with no command outstanding");
				err_count++;
			end else begin
				exp = pending_results.pop_front();
				results_checked++;
				status_seen[int'(exp.st)]++;
				if (chunk_address !== exp.addr) begin
					$error("chunk_address: expected %h, got %h", exp.addr, chunk_address);
					err_count++;
				end
				if (status !== exp.st) begin
					$error("status: expected %0d, got %0d", exp.st, status);
					err_count++;
				end
				if (free_count !== exp.count) begin
					$error("free_count: expected %0d, got %0d", exp.count, free_count);
					err_count++;
				end
			end
		end
	end

	// watchdog: cycles with no transaction on any port
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_cmd(input cmd_t c, input logic [31:0] a, output pool_result_t r);
		int gap;
		gap = 0;
		while (gap < 50 && $urandom_range(99) < idle_pct) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		cmd     <= c;
		address <= a;
		do @(posedge clk); while (busy);
		r = predict_step(c, a);
		pending_results.push_back(r);
		if (c == CMD_REBUILD) rebuilds++;
	endtask

	// address field is ignored except on free, so junk goes there
	task automatic send_op(input cmd_t c);
		pool_result_t r;
		send_cmd(c, $urandom, r);
	endtask

	task automatic send_free(input logic [31:0] a);
		pool_result_t r;
		send_cmd(CMD_FREE, a, r);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_config(input logic [31:0] b, input logic [31:0] l,
			input logic [31:0] ch, input logic [31:0] al);
		cfg_we    <= 1'b1;
		cfg_index <= REG_BASE;
		cfg_data  <= b;
		@(posedge clk);
		reg_base  = b;
		cfg_index <= REG_LENGTH;
		cfg_data  <= l;
		@(posedge clk);
		reg_len   = l;
		cfg_index <= REG_CHUNK;
		cfg_data  <= ch;
		@(posedge clk);
		reg_chunk = ch[15:0];
		cfg_index <= REG_ALIGN;
		cfg_data  <= al;
		@(posedge clk);
		reg_align = al[3:0];
		cfg_we    <= 1'b0;
		geometries++;
	endtask

	task automatic random_geometry();
		longint unsigned align_bytes, chunk, core, b, l, first;
		int unsigned al, chunk_req, count;
		logic [31:0] junk;
		junk = $urandom;
		if ($urandom_range(99) < 15) begin
			write_config($urandom, $urandom, $urandom, $urandom);
		end else begin
			al = ($urandom_range(99) < 85) ? $urandom_range(6, 0) : $urandom_range(15, 7);
			chunk_req = ($urandom_range(99) < 85) ? $urandom_range(64, 1)
				: $urandom_range(65535, 1);
			align_bytes = 64'd1 << al;
			chunk = (chunk_req + align_bytes - 1) & ~(align_bytes - 1);
			count = ($urandom_range(99) < 70) ? $urandom_range(40, 1) : $urandom_range(300, 41);
			core  = count * chunk + $urandom_range(int'(chunk) - 1, 0);
			b     = {32'd0, $urandom} % (64'h1_0000_0000 - core - align_bytes);
			first = (b + align_bytes - 1) & ~(align_bytes - 1);
			l     = core + (first - b);
			if (junk[0])
				write_config(b[31:0], l[31:0], {junk[31:16], chunk_req[15:0]},
					{junk[31:4], al[3:0]});
			else
				write_config(b[31:0], l[31:0], chunk_req, al);
		end
	endtask

	task automatic test_empty_after_reset();
		// reset geometry has zero length, so a rebuild must fault
		send_op(CMD_ALLOC);
		send_free('0);
		send_free(32'h0000_0008);
		send_op(CMD_NOP);
		send_op(CMD_REBUILD);
		wait_idle();
	endtask

	task automatic test_small_pool();
		// base 0x1003 aligns to 0x1008; two 8-byte chunks fit in the trimmed length
		write_config(32'h0000_1003, 32'd21, 32'd5, 32'd3);
		send_op(CMD_REBUILD);
		send_op(CMD_ALLOC);
		send_op(CMD_ALLOC);
		send_op(CMD_ALLOC);
		send_free('0);
		send_free(32'h0000_1007);
		send_free(32'h0000_1018);
		send_free(32'h0000_1017);
		send_free(32'h0000_1008);
		send_op(CMD_NOP);
		send_op(CMD_ALLOC);
		send_op(CMD_REBUILD);
		send_free(32'hFFFF_FFFF);
		wait_idle();
	endtask

	task automatic test_overflow_and_top_of_memory();
		// 64 KiB chunks over the whole space: overflow, stack stays full
		write_config(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'd15);
		send_op(CMD_REBUILD);
		send_free(32'h0000_0004);
		send_op(CMD_ALLOC);
		wait_idle();
		// pool ending exactly at the top of the address space
		write_config(32'hFFFF_FF00, 32'h0000_0100, 32'd16, 32'd4);
		send_op(CMD_REBUILD);
		send_op(CMD_ALLOC);
		wait_idle();
	endtask

	task automatic test_bad_geometry();
		write_config(32'hFFFF_FFF9, 32'h0000_0100, 32'd16, 32'd4);
		send_op(CMD_REBUILD);
		wait_idle();
		write_config(32'hFFFF_FF00, 32'h0000_0101, 32'd16, 32'd4);
		send_op(CMD_REBUILD);
		wait_idle();
		write_config(32'h0000_1001, 32'd3, 32'd8, 32'd3);
		send_op(CMD_REBUILD);
		wait_idle();
		write_config(32'h0000_0000, 32'd0, 32'd0, 32'd0);
		send_op(CMD_REBUILD);
		wait_idle();
		write_config(32'h0000_1000, 32'd7, 32'd8, 32'd3);
		send_op(CMD_REBUILD);
		send_free(32'h0000_1000);
		wait_idle();
	endtask

	task automatic test_random_traffic(input int pct, input int n_items);
		logic [31:0] held[$];
		pool_result_t r;
		int k, pick, idx;
		idle_pct = pct;
		wait_idle();
		random_geometry();
		send_op(CMD_REBUILD);
		held.delete();
		for (k = 0; k < n_items; k++) begin
			pick = $urandom_range(99);
			if (pick < 45 || (pick < 78 && held.size() == 0)) begin
				send_cmd(CMD_ALLOC, $urandom, r);
				if (r.st == ST_OK) held.push_back(r.addr);
			end else if (pick < 78) begin
				idx = $urandom_range(held.size() - 1, 0);
				send_free(held[idx]);
				held.delete(idx);
			end else if (pick < 84 && pool_usable != 0) begin
				send_free(pool_start + ($urandom % pool_usable));
			end else if (pick < 88) begin
				send_free($urandom);
			end else if (pick < 91) begin
				send_free('0);
			end else if (pick < 95) begin
				send_op(CMD_NOP);
			end else if (pick < 97) begin
				send_op(CMD_REBUILD);
				held.delete();
			end else begin
				wait_idle();
				random_geometry();
				send_op(CMD_REBUILD);
				held.delete();
			end
		end
		wait_idle();
	endtask

	initial begin
		start     = 1'b0;
		cmd       = CMD_NOP;
		address   = '0;
		cfg_we    = 1'b0;
		cfg_index = REG_BASE;
		cfg_data  = '0;
		arst_n    = 1'b0;
		err_count       = 0;
		results_checked = 0;
		rebuilds        = 0;
		geometries      = 0;
		idle_pct        = 0;
		quiet_cycles    = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
		reg_base    = '0;
		reg_len     = '0;
		reg_chunk   = CHUNK_REQ_RST;
		reg_align   = ALIGN_RST;
		pool_depth  = 0;
		pool_start  = '0;
		pool_usable = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_empty_after_reset();
		test_small_pool();
		test_overflow_and_top_of_memory();
		test_bad_geometry();
		test_random_traffic(14, 600);
		test_random_traffic(71, 600);
		test_random_traffic(0, 600);

		repeat (8) @(posedge clk);
		$display("checked %0d results, %0d rebuilds over %0d pool geometries",
			results_checked, rebuilds, geometries);
		$display("status mix: ok %0d, empty %0d, out of bounds %0d, null %0d, fault %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
